/* hw/rtl/vnt_pkg.sv */
// Shared constants and opcodes for the value noise turbulence core.
`timescale 1ns / 1ps
package vnt_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned FracW        = 16;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned DataW        = 16;
  localparam int unsigned OutW         = 17;
  localparam int unsigned OctW         = 4;
  localparam int unsigned MaxOctaves   = 8;
  localparam int unsigned OpW          = 3;

  typedef logic [OpW-1:0] opcode_t;
  localparam opcode_t OP_WR_VALUE = 3'd0;
  localparam opcode_t OP_WR_PX    = 3'd1;
  localparam opcode_t OP_WR_PY    = 3'd2;
  localparam opcode_t OP_WR_PZ    = 3'd3;
  localparam opcode_t OP_QUERY    = 3'd4;
endpackage

/* hw/rtl/vnt_in_if.sv */
// Input channel: table writes and queries.
`timescale 1ns / 1ps
interface vnt_in_if;
  logic                          valid;
  logic                          ready;
  vnt_pkg::opcode_t              opcode;
  logic [vnt_pkg::IdxW-1:0]      table_index;
  logic [vnt_pkg::DataW-1:0]     write_data;
  logic [vnt_pkg::CoordW-1:0]    point_x;
  logic [vnt_pkg::CoordW-1:0]    point_y;
  logic [vnt_pkg::CoordW-1:0]    point_z;
  modport source (output valid, opcode, table_index, write_data, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, opcode, table_index, write_data, point_x, point_y, point_z,
                output ready);
endinterface

/* hw/rtl/vnt_out_if.sv */
// Result channel: turbulence sums.
`timescale 1ns / 1ps
interface vnt_out_if;
  logic                        valid;
  logic                        ready;
  logic [vnt_pkg::OutW-1:0]    noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

/* hw/rtl/value_noise_turbulence_core.sv */
// Value noise turbulence core: table memories, octave sequencer and corner pipeline.
// A table write leaves the core ready for the next item. A query runs n octaves, n being
// octave_count saturated to 8: per octave, smoothing and permutation reads (ST_SQ, ST_SS,
// ST_SW), the corner loop, bound by the single read port of the value table (one corner
// a cycle plus pipeline fill), and one accumulate step (ST_ACC). Tables come up
// undefined and must be written before a query uses them. The next item is taken
// while a result waits in the output register.
`timescale 1ns / 1ps
module value_noise_turbulence_core (
  input  logic                      clk,
  input  logic                      rst_n,
  vnt_in_if.sink                    in_ch,
  vnt_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [vnt_pkg::OctW-1:0]  cfg_wdata
);
  localparam int unsigned FW = vnt_pkg::FracW;
  localparam int unsigned IW = vnt_pkg::IdxW;
  localparam int unsigned CW = vnt_pkg::CoordW;
  localparam int unsigned WW = FW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SS   = 3'd2;
  localparam logic [2:0] ST_SW   = 3'd3;
  localparam logic [2:0] ST_CRN  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [WW-1:0] ONE = WW'(1) << FW;

  logic [2:0] state_r, state_nxt;
  logic [vnt_pkg::OctW-1:0] oct_cnt_r, oct_r, n_r;
  logic [3:0] k_r;
  logic [CW-1:0] x_r, y_r, z_r;
  logic [FW-1:0] f2_r [3];
  logic [WW-1:0] s_r [3];
  logic [WW-1:0] wab_r [4];
  logic [WW-1:0] wt_r, prod_r;
  logic [19:0] sum_r;
  logic [vnt_pkg::OutW-1:0] acc_r;
  logic [IW-1:0] px0_r, px1_r, py0_r, py1_r, pz0_r, pz1_r;
  logic out_valid_r;
  logic [vnt_pkg::OutW-1:0] out_value_r;

  logic [vnt_pkg::DataW-1:0] val_mem [vnt_pkg::TableEntries];
  logic [IW-1:0] px_mem [vnt_pkg::TableEntries];
  logic [IW-1:0] py_mem [vnt_pkg::TableEntries];
  logic [IW-1:0] pz_mem [vnt_pkg::TableEntries];
  logic [vnt_pkg::DataW-1:0] val_rd_r;
  logic [IW-1:0] px_rd_r, py_rd_r, pz_rd_r;

  logic in_acc, wr_val, wr_px, wr_py, wr_pz, is_query, last_oct;
  logic [IW-1:0] pxa, pya, pza, hash;
  logic [FW-1:0] fr [3];
  logic [vnt_pkg::OctW-1:0] n_sat;
  logic [WW-1:0] wc;
  logic [2*WW-1:0] wt_prod;
  logic [WW+FW-1:0] vprod;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign wr_val   = in_acc && (in_ch.opcode == vnt_pkg::OP_WR_VALUE);
  assign wr_px    = in_acc && (in_ch.opcode == vnt_pkg::OP_WR_PX);
  assign wr_py    = in_acc && (in_ch.opcode == vnt_pkg::OP_WR_PY);
  assign wr_pz    = in_acc && (in_ch.opcode == vnt_pkg::OP_WR_PZ);
  assign is_query = in_acc && (in_ch.opcode == vnt_pkg::OP_QUERY);
  assign n_sat    = (oct_cnt_r > vnt_pkg::OctW'(vnt_pkg::MaxOctaves))
                    ? vnt_pkg::OctW'(vnt_pkg::MaxOctaves) : oct_cnt_r;
  assign last_oct = (oct_r + 1'b1) == n_r;

  assign fr[0] = x_r[FW-1:0];
  assign fr[1] = y_r[FW-1:0];
  assign fr[2] = z_r[FW-1:0];

  // permutation reads for cell+1 (ST_SS) follow those for the cell (ST_SQ) in the next cycle
  assign pxa = (state_r == ST_SS) ? x_r[CW-1:FW] + 1'b1 : x_r[CW-1:FW];
  assign pya = (state_r == ST_SS) ? y_r[CW-1:FW] + 1'b1 : y_r[CW-1:FW];
  assign pza = (state_r == ST_SS) ? z_r[CW-1:FW] + 1'b1 : z_r[CW-1:FW];

  assign hash = (k_r[2] ? px1_r : px0_r) ^ (k_r[1] ? py1_r : py0_r)
              ^ (k_r[0] ? pz1_r : pz0_r);
  assign wc      = k_r[0] ? s_r[2] : ONE - s_r[2];
  assign wt_prod = wab_r[k_r[2:1]] * wc;
  assign vprod   = wt_r * val_rd_r;

  always_ff @(posedge clk) begin
    if (wr_val) val_mem[in_ch.table_index] <= in_ch.write_data;
    val_rd_r <= val_mem[hash];
  end
  always_ff @(posedge clk) begin
    if (wr_px) px_mem[in_ch.table_index] <= in_ch.write_data[IW-1:0];
    px_rd_r <= px_mem[pxa];
  end
  always_ff @(posedge clk) begin
    if (wr_py) py_mem[in_ch.table_index] <= in_ch.write_data[IW-1:0];
    py_rd_r <= py_mem[pya];
  end
  always_ff @(posedge clk) begin
    if (wr_pz) pz_mem[in_ch.table_index] <= in_ch.write_data[IW-1:0];
    pz_rd_r <= pz_mem[pza];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (is_query) state_nxt = (n_sat == '0) ? ST_FIN : ST_SQ;
      ST_SQ:   state_nxt = ST_SS;
      ST_SS:   state_nxt = ST_SW;
      ST_SW:   state_nxt = ST_CRN;
      ST_CRN:  if (k_r == 4'd9) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_oct ? ST_FIN : ST_SQ;
      ST_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oct_cnt_r   <= vnt_pkg::OctW'(7);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) oct_cnt_r <= cfg_wdata;
      if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) out_value_r <= acc_r;
    unique case (state_r)
      ST_IDLE: begin
        x_r   <= in_ch.point_x;
        y_r   <= in_ch.point_y;
        z_r   <= in_ch.point_z;
        n_r   <= n_sat;
        oct_r <= '0;
        acc_r <= '0;
      end
      ST_SQ: begin
        for (int i = 0; i < 3; i++) f2_r[i] <= FW'(((2*FW)'(fr[i]) * fr[i]) >> FW);
      end
      ST_SS: begin
        for (int i = 0; i < 3; i++)
          s_r[i] <= WW'(((2*WW)'(f2_r[i])
                         * (18'(3) * (18'(1) << FW) - {1'b0, fr[i], 1'b0})) >> FW);
        px0_r <= px_rd_r;
        py0_r <= py_rd_r;
        pz0_r <= pz_rd_r;
      end
      ST_SW: begin
        px1_r <= px_rd_r;
        py1_r <= py_rd_r;
        pz1_r <= pz_rd_r;
        for (int j = 0; j < 4; j++)
          wab_r[j] <= WW'(((2*WW)'((j >= 2) ? s_r[0] : ONE - s_r[0])
                         * ((j % 2 == 1) ? s_r[1] : ONE - s_r[1])) >> FW);
        k_r   <= '0;
        sum_r <= '0;
      end
      ST_CRN: begin
        // weight, then weighted value, then sum: three corner stages in flight
        if (k_r < 4'd8) wt_r <= wt_prod[FW +: WW];
        if (k_r >= 4'd1 && k_r <= 4'd8) prod_r <= vprod[FW +: WW];
        if (k_r >= 4'd2) sum_r <= sum_r + 20'(prod_r);
        k_r <= k_r + 1'b1;
      end
      ST_ACC: begin
        acc_r <= acc_r + (vnt_pkg::OutW'(sum_r[FW-1:0]) >> oct_r);
        x_r   <= x_r << 1;
        y_r   <= y_r << 1;
        z_r   <= z_r << 1;
        oct_r <= oct_r + 1'b1;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_value_r;
endmodule

/* hw/rtl/vnt_checker.sv */
// Port-level checks for the value noise turbulence core.
`timescale 1ns / 1ps
module vnt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input vnt_pkg::opcode_t          in_opcode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [vnt_pkg::OutW-1:0]  out_noise_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_noise_value))
    else $error("result word changed while stalled");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == vnt_pkg::OP_QUERY |=> !in_ready)
    else $error("query did not occupy the core");
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode != vnt_pkg::OP_QUERY |=> in_ready)
    else $error("table write stalled the input");
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word without a query in flight");
endmodule

bind value_noise_turbulence_core vnt_checker u_vnt_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.opcode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_noise_value(out_ch.noise_value)
);

/* tb/tb_value_noise_turbulence_core.sv */
// Testbench for the value noise turbulence core: table loads, queries and octave settings.
`timescale 1ns / 1ps
module tb_value_noise_turbulence_core;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vnt_pkg::OctW-1:0] cfg_wdata;

  vnt_in_if  in_ch ();
  vnt_out_if out_ch ();

  value_noise_turbulence_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the block's tables and register.
  logic [vnt_pkg::DataW-1:0] value_mem [vnt_pkg::TableEntries];
  logic [vnt_pkg::IdxW-1:0]  perm_x [vnt_pkg::TableEntries];
  logic [vnt_pkg::IdxW-1:0]  perm_y [vnt_pkg::TableEntries];
  logic [vnt_pkg::IdxW-1:0]  perm_z [vnt_pkg::TableEntries];
  logic [vnt_pkg::OctW-1:0]  octaves;

  logic [vnt_pkg::OutW-1:0] noise_expected [$];
  int errors;
  int queries_sent;
  int writes_sent;
  int ignored_sent;
  int results_seen;
  bit steady;  // no idling on either side while set

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [vnt_pkg::CoordW-1:0] COORD_MAX = {vnt_pkg::CoordW{1'b1}};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic longint unsigned smoothstep(longint unsigned f);
    longint unsigned f2;
    f2 = (f * f) >> vnt_pkg::FracW;
    return (f2 * (3 * (64'd1 << vnt_pkg::FracW) - 2 * f)) >> vnt_pkg::FracW;
  endfunction

  function automatic longint unsigned noise_sample(longint unsigned x, longint unsigned y,
                                                   longint unsigned z);
    longint unsigned one, su, sv, sw, wa, wb, wc, wab, wt, sum;
    logic [vnt_pkg::IdxW-1:0] cx, cy, cz, h;
    one = 64'd1 << vnt_pkg::FracW;
    cx = vnt_pkg::IdxW'(x >> vnt_pkg::FracW);
    cy = vnt_pkg::IdxW'(y >> vnt_pkg::FracW);
    cz = vnt_pkg::IdxW'(z >> vnt_pkg::FracW);
    su = smoothstep(x & (one - 1));
    sv = smoothstep(y & (one - 1));
    sw = smoothstep(z & (one - 1));
    sum = 0;
    for (int a = 0; a < 2; a++) begin
      wa = a ? su : one - su;
      for (int b = 0; b < 2; b++) begin
        wb = b ? sv : one - sv;
        wab = (wa * wb) >> vnt_pkg::FracW;
        for (int c = 0; c < 2; c++) begin
          wc = c ? sw : one - sw;
          wt = (wab * wc) >> vnt_pkg::FracW;
          h = perm_x[vnt_pkg::IdxW'(cx + a)] ^ perm_y[vnt_pkg::IdxW'(cy + b)]
            ^ perm_z[vnt_pkg::IdxW'(cz + c)];
          sum += (wt * value_mem[h]) >> vnt_pkg::FracW;
        end
      end
    end
    return sum & 64'hFFFF;
  endfunction

  function automatic logic [vnt_pkg::OutW-1:0] turbulence(logic [vnt_pkg::CoordW-1:0] px,
                                                          logic [vnt_pkg::CoordW-1:0] py,
                                                          logic [vnt_pkg::CoordW-1:0] pz);
    longint unsigned acc;
    int n;
    acc = 0;
    n = (octaves > vnt_pkg::MaxOctaves) ? vnt_pkg::MaxOctaves : octaves;
    for (int o = 0; o < n; o++) begin
      acc += noise_sample(px, py, pz) >> o;
      px = px << 1;
      py = py << 1;
      pz = pz << 1;
    end
    return vnt_pkg::OutW'(acc);
  endfunction

  // Update the tables or queue the expected sum for one accepted word.
  task automatic track_word(vnt_pkg::opcode_t op, logic [vnt_pkg::IdxW-1:0] idx,
                            logic [vnt_pkg::DataW-1:0] data,
                            logic [vnt_pkg::CoordW-1:0] px, logic [vnt_pkg::CoordW-1:0] py,
                            logic [vnt_pkg::CoordW-1:0] pz);
    case (op)
      vnt_pkg::OP_WR_VALUE: begin value_mem[idx] = data; writes_sent++; end
      vnt_pkg::OP_WR_PX: begin perm_x[idx] = data[vnt_pkg::IdxW-1:0]; writes_sent++; end
      vnt_pkg::OP_WR_PY: begin perm_y[idx] = data[vnt_pkg::IdxW-1:0]; writes_sent++; end
      vnt_pkg::OP_WR_PZ: begin perm_z[idx] = data[vnt_pkg::IdxW-1:0]; writes_sent++; end
      vnt_pkg::OP_QUERY: begin
        noise_expected.push_back(turbulence(px, py, pz));
        queries_sent++;
      end
      default: ignored_sent++;
    endcase
  endtask

  task automatic send_word(vnt_pkg::opcode_t op, logic [vnt_pkg::IdxW-1:0] idx,
                           logic [vnt_pkg::DataW-1:0] data,
                           logic [vnt_pkg::CoordW-1:0] px, logic [vnt_pkg::CoordW-1:0] py,
                           logic [vnt_pkg::CoordW-1:0] pz);
    if (!steady && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.table_index <= idx;
    in_ch.write_data  <= data;
    in_ch.point_x     <= px;
    in_ch.point_y     <= py;
    in_ch.point_z     <= pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_word(op, idx, data, px, py, pz);
  endtask

  task automatic send_query(logic [vnt_pkg::CoordW-1:0] px, logic [vnt_pkg::CoordW-1:0] py,
                            logic [vnt_pkg::CoordW-1:0] pz);
    send_word(vnt_pkg::OP_QUERY, vnt_pkg::IdxW'($urandom), vnt_pkg::DataW'($urandom),
              px, py, pz);
  endtask

  // Drop valid, wait until every sum has come back, then past any write still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic set_octaves(logic [vnt_pkg::OctW-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    octaves = n;
  endtask

  function automatic logic [vnt_pkg::CoordW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return COORD_MAX;
      2: return {8'($urandom_range(255)), 16'h0000};
      3: return {8'($urandom_range(255)), 16'hFFFF};
      4: return {8'($urandom_range(255)), 16'h8000};
      default: return vnt_pkg::CoordW'($urandom);
    endcase
  endfunction

  // Result side: random stalls on ready, compare each sum in order.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 34);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (noise_expected.size() == 0) begin
        $error("unexpected result noise_value=%0h", out_ch.noise_value);
        errors++;
      end else begin
        if (out_ch.noise_value !== noise_expected[0]) begin
          $error("noise_value: expected %0h, got %0h", noise_expected[0],
                 out_ch.noise_value);
          errors++;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  // Every entry is written before any query, in shuffled order.
  task automatic test_load_tables();
    int order [vnt_pkg::TableEntries];
    for (int i = 0; i < vnt_pkg::TableEntries; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < vnt_pkg::TableEntries; i++) begin
      send_word(vnt_pkg::OP_WR_VALUE, vnt_pkg::IdxW'(order[i]),
                vnt_pkg::DataW'((i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : $urandom),
                '0, '0, '0);
      send_word(vnt_pkg::OP_WR_PX, vnt_pkg::IdxW'(order[i]), vnt_pkg::DataW'($urandom),
                '0, '0, '0);
      send_word(vnt_pkg::OP_WR_PY, vnt_pkg::IdxW'(order[i]), vnt_pkg::DataW'($urandom),
                '0, '0, '0);
      send_word(vnt_pkg::OP_WR_PZ, vnt_pkg::IdxW'(order[i]), vnt_pkg::DataW'($urandom),
                '0, '0, '0);
    end
  endtask

  task automatic test_directed_queries();
    send_query('0, '0, '0);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
    send_query(24'h018000, 24'h7F4000, 24'hFFC000);
    send_query(24'h800000, '0, COORD_MAX);
    for (logic [2:0] op = OP_UNUSED_LO; op != 3'd0; op++)
      send_word(vnt_pkg::opcode_t'(op), vnt_pkg::IdxW'($urandom), vnt_pkg::DataW'($urandom),
                COORD_MAX, COORD_MAX, COORD_MAX);
    send_query(24'h123456, 24'hABCDEF, 24'h0F0F0F);
    // Random points, many of them on cell edges.
    for (int i = 0; i < 4; i++) send_query(pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic test_octave_settings();
    logic [vnt_pkg::OctW-1:0] settings [6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd3};
    foreach (settings[i]) begin
      set_octaves(settings[i]);
      send_query('0, '0, '0);
      send_query(COORD_MAX, COORD_MAX, COORD_MAX);
      send_query(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic test_random_traffic();
    int r;
    for (int i = 0; i < 100; i++) begin
      if (i % 30 == 29) set_octaves(vnt_pkg::OctW'($urandom_range(15)));
      steady = (i >= 40 && i < 70);
      r = $urandom_range(99);
      if (r < 80) send_query(pick_coord(), pick_coord(), pick_coord());
      else if (r < 95)
        send_word(vnt_pkg::opcode_t'($urandom_range(vnt_pkg::OP_WR_PZ)),
                  vnt_pkg::IdxW'($urandom), vnt_pkg::DataW'($urandom), '0, '0, '0);
      else send_word(vnt_pkg::opcode_t'($urandom_range(7, OP_UNUSED_LO)),
                     vnt_pkg::IdxW'($urandom), vnt_pkg::DataW'($urandom),
                     vnt_pkg::CoordW'($urandom), vnt_pkg::CoordW'($urandom),
                     vnt_pkg::CoordW'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    errors = 0;
    queries_sent = 0;
    writes_sent = 0;
    ignored_sent = 0;
    results_seen = 0;
    steady = 1'b0;
    octaves = 4'd7;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = vnt_pkg::OP_WR_VALUE;
    in_ch.table_index = '0;
    in_ch.write_data = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_tables();
    test_directed_queries();
    test_octave_settings();
    set_octaves(4'd7);
    test_random_traffic();
    drain();

    $display("Covered %0d table writes, %0d queries and %0d unused opcodes",
             writes_sent, queries_sent, ignored_sent);
    $display("over octave counts 0 to 15; %0d sums checked", results_seen);
    if (errors == 0 && noise_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
